>>> rtl/core/emm_pkg.sv
// Shared types, constants and codes of the expanded memory page mapper.
package emm_pkg;

    // Sizing
    localparam int NUM_HANDLES     = 256;
    localparam int NUM_FRAME_SLOTS = 4;
    localparam int MAX_PAGES       = 2048;
    localparam int PAGE_BYTES      = 16384;
    localparam int HANDLE_W        = $clog2(NUM_HANDLES);
    localparam int SLOT_W          = $clog2(NUM_FRAME_SLOTS);
    localparam int PAGE_OFF_W      = $clog2(PAGE_BYTES);
    localparam int SAVED_DEPTH     = NUM_HANDLES * NUM_FRAME_SLOTS;

    // Field widths of the frame map entries, handle table entries and counters
    localparam int HANDLE_FIELD_W = 8;
    localparam int PAGE_FIELD_W   = 11;
    localparam int COUNT_W        = 12;
    localparam int HCOUNT_W       = 9;

    // Fixed values
    localparam logic [7:0]  VERSION_BYTE  = 8'h32;
    localparam logic [15:0] UNMAP_PAGE    = 16'hFFFF;
    localparam logic [15:0] FRAME_SEG_RST = 16'hE000;
    localparam logic [11:0] HANDLE0_PAGES = 12'd4;

    // Configuration register indexes
    localparam logic REG_FRAME_SEGMENT = 1'b0;
    localparam logic REG_TOTAL_PAGES   = 1'b1;

    // Service function codes
    localparam logic [7:0] FN_STATUS      = 8'h40;
    localparam logic [7:0] FN_FRAME_SEG   = 8'h41;
    localparam logic [7:0] FN_PAGE_COUNTS = 8'h42;
    localparam logic [7:0] FN_ALLOCATE    = 8'h43;
    localparam logic [7:0] FN_MAP         = 8'h44;
    localparam logic [7:0] FN_DEALLOCATE  = 8'h45;
    localparam logic [7:0] FN_VERSION     = 8'h46;
    localparam logic [7:0] FN_SAVE_MAP    = 8'h47;
    localparam logic [7:0] FN_RESTORE_MAP = 8'h48;
    localparam logic [7:0] FN_HANDLE_CNT  = 8'h4B;
    localparam logic [7:0] FN_HANDLE_PGS  = 8'h4C;

    // Status codes
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_BAD_HANDLE    = 4'd1;
    localparam logic [3:0] ST_UNKNOWN_FN    = 4'd2;
    localparam logic [3:0] ST_NO_HANDLE     = 4'd3;
    localparam logic [3:0] ST_MAP_SAVED     = 4'd4;
    localparam logic [3:0] ST_OVER_TOTAL    = 4'd5;
    localparam logic [3:0] ST_OVER_FREE     = 4'd6;
    localparam logic [3:0] ST_ZERO_COUNT    = 4'd7;
    localparam logic [3:0] ST_BAD_FRAME     = 4'd8;
    localparam logic [3:0] ST_ALREADY_SAVED = 4'd9;
    localparam logic [3:0] ST_NONE_SAVED    = 4'd10;
    localparam logic [3:0] ST_PAGE_RANGE    = 4'd11;

    // One frame slot mapping
    typedef struct packed {
        logic                      valid;
        logic [HANDLE_FIELD_W-1:0] handle;
        logic [PAGE_FIELD_W-1:0]   page;
    } slot_map_t;

    // One handle table entry
    typedef struct packed {
        logic               in_use;
        logic               saved;
        logic [COUNT_W-1:0] pages;
    } htab_entry_t;

    // Request payload, last field in the low bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [16:0] window_offset;
        logic [15:0] handle_number;
        logic [15:0] page_or_count;
        logic [7:0]  frame_slot;
        logic [7:0]  function_code;
    } req_t;

    // Result payload, last field in the low bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [13:0] backing_offset;
        logic [10:0] backing_page;
        logic [7:0]  backing_handle;
        logic        mapped;
        logic [7:0]  result_al;
        logic [15:0] result_dx;
        logic [15:0] result_bx;
        logic [3:0]  status;
    } res_t;

    localparam int S_TDATA_W = $bits(req_t);
    localparam int M_TDATA_W = $bits(res_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ASCAN,
        S_ACHK,
        S_SAVE,
        S_RRD,
        S_RHRD,
        S_RCHK,
        S_DONE
    } emm_state_t;

endpackage

>>> rtl/core/emm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module emm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/emm_htab.sv
// Handle table: RAM of handle entries plus per-entry valid bits for reset values.
module emm_htab (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [emm_pkg::HANDLE_W-1:0] rd_addr,
    output emm_pkg::htab_entry_t         rd_entry,
    input  logic                         wr_en,
    input  logic [emm_pkg::HANDLE_W-1:0] wr_addr,
    input  emm_pkg::htab_entry_t         wr_entry
);

    logic [emm_pkg::NUM_HANDLES-1:0] valid_reg;
    logic                            rd_valid_reg;
    logic [emm_pkg::HANDLE_W-1:0]    rd_addr_reg;
    logic [$bits(emm_pkg::htab_entry_t)-1:0] ram_q;
    emm_pkg::htab_entry_t            rst_entry;

    emm_ram #(
        .WIDTH ($bits(emm_pkg::htab_entry_t)),
        .DEPTH (emm_pkg::NUM_HANDLES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Valid bits: an entry never written reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr;
    end

    // Reset value: handle 0 in use with four pages, others free
    always_comb begin
        rst_entry        = '0;
        rst_entry.in_use = (rd_addr_reg == '0);
        rst_entry.pages  = (rd_addr_reg == '0) ? emm_pkg::HANDLE0_PAGES : '0;
        rd_entry         = rd_valid_reg ? emm_pkg::htab_entry_t'(ram_q) : rst_entry;
    end

endmodule

>>> rtl/core/expanded_memory_page_mapper_top.sv
// Top level of the expanded memory page mapper: sequencer, frame map and result stage.
//
// Each request is either a byte access in the 64 KiB page frame (s_tuser low) or a
// service call (s_tuser high) and yields exactly one result. Every request first reads
// the handle table RAM, whose read data is registered, so a byte access or a simple call
// passes through the execute and done states before its result is loaded into the output
// register. Allocate walks the handle table with a read state and a check state per handle
// examined, over handles 1 to NUM_HANDLES-2; save map makes four slot writes into the
// saved-map RAM; restore map does, per slot, a saved-map read followed by a handle table
// read of the slot's handle. A result waiting on m_tready holds the sequencer before it
// goes idle. A new request is taken once the sequencer is idle, while an earlier result
// may still wait in the output register. Configuration is written through cfg_wr_en /
// cfg_addr / cfg_wdata only while idle: the user is bound to this, and the block itself
// does not enforce it.
module expanded_memory_page_mapper_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: function_code, frame_slot, page_or_count, handle_number, window_offset
    input  logic [emm_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: action
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: status, result_bx, result_dx, result_al, mapped, backing_handle,
    //        backing_page, backing_offset
    output logic [emm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [15:0]                   cfg_wdata
);

    localparam int HW = emm_pkg::HANDLE_W;
    localparam int SW = emm_pkg::SLOT_W;
    localparam int NS = emm_pkg::NUM_FRAME_SLOTS;

    emm_pkg::req_t        s_req;
    emm_pkg::emm_state_t  state_reg, state_next;

    // Captured request
    logic                 act_reg;
    logic [7:0]           fn_reg;
    logic [7:0]           slot_reg;
    logic [15:0]          pc_reg;
    logic [15:0]          h_reg;
    logic [16:0]          off_reg;

    // Sequencer working registers
    emm_pkg::htab_entry_t ent_reg, ent_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [HW-1:0]        scan_reg, scan_next;
    emm_pkg::slot_map_t   sv_reg, sv_next;
    emm_pkg::res_t        res_reg, res_next;
    emm_pkg::res_t        out_reg;
    logic                 m_tvalid_reg;

    // Architectural state in flops
    emm_pkg::slot_map_t   fm_reg [NS];
    emm_pkg::slot_map_t   fm_next [NS];
    logic [emm_pkg::COUNT_W-1:0]  piu_reg, piu_next;
    logic [emm_pkg::HCOUNT_W-1:0] hiu_reg, hiu_next;
    logic [15:0]                  seg_reg;
    logic [emm_pkg::COUNT_W-1:0]  total_reg;

    // Handle table port
    logic [HW-1:0]        ht_raddr;
    emm_pkg::htab_entry_t ht_rent;
    logic                 ht_we;
    logic [HW-1:0]        ht_waddr;
    emm_pkg::htab_entry_t ht_went;

    // Saved map RAM port
    logic                 sv_we;
    logic [HW+SW-1:0]     sv_waddr;
    logic [$bits(emm_pkg::slot_map_t)-1:0] sv_wdata;
    logic [HW+SW-1:0]     sv_raddr;
    logic [$bits(emm_pkg::slot_map_t)-1:0] sv_rdata;
    emm_pkg::slot_map_t   sv_rslot;

    // Decode helpers
    logic                 accept;
    logic [HW-1:0]        h_idx;
    logic                 hok;
    logic [emm_pkg::COUNT_W-1:0] tot;
    logic [16:0]          alloc_sum;
    logic [SW-1:0]        off_slot;
    logic                 restore_ok;

    assign s_req    = emm_pkg::req_t'(s_tdata);
    assign s_tready = (state_reg == emm_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = out_reg;
    assign m_tvalid = m_tvalid_reg;
    assign h_idx    = h_reg[HW-1:0];
    assign sv_rslot = emm_pkg::slot_map_t'(sv_rdata);

    emm_htab u_htab (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (ht_raddr),
        .rd_entry (ht_rent),
        .wr_en    (ht_we),
        .wr_addr  (ht_waddr),
        .wr_entry (ht_went)
    );

    emm_ram #(
        .WIDTH ($bits(emm_pkg::slot_map_t)),
        .DEPTH (emm_pkg::SAVED_DEPTH)
    ) u_saved_ram (
        .aclk    (aclk),
        .wr_en   (sv_we),
        .wr_addr (sv_waddr),
        .wr_data (sv_wdata),
        .rd_addr (sv_raddr),
        .rd_data (sv_rdata)
    );

    // Effective total and common checks
    always_comb begin
        tot = (total_reg > emm_pkg::COUNT_W'(emm_pkg::MAX_PAGES))
            ? emm_pkg::COUNT_W'(emm_pkg::MAX_PAGES) : total_reg;
        hok        = (h_reg < 16'(emm_pkg::NUM_HANDLES)) && ht_rent.in_use;
        alloc_sum  = 17'(piu_reg) + 17'(pc_reg);
        off_slot   = off_reg[emm_pkg::PAGE_OFF_W +: SW];
        restore_ok = sv_reg.valid
                  && ({1'b0, sv_reg.handle} < 9'(emm_pkg::NUM_HANDLES))
                  && ht_rent.in_use
                  && ({1'b0, sv_reg.page} < ht_rent.pages);
    end

    // Memory addresses
    always_comb begin
        unique case (state_reg)
            emm_pkg::S_IDLE:  ht_raddr = s_req.handle_number[HW-1:0];
            emm_pkg::S_ASCAN: ht_raddr = scan_reg;
            emm_pkg::S_RHRD:  ht_raddr = sv_rslot.handle[HW-1:0];
            default:          ht_raddr = h_idx;
        endcase
        sv_raddr = {h_idx, idx_reg};
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= emm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, table updates and result
    always_comb begin
        state_next = state_reg;
        ent_next   = ent_reg;
        idx_next   = idx_reg;
        scan_next  = scan_reg;
        sv_next    = sv_reg;
        res_next   = res_reg;
        piu_next   = piu_reg;
        hiu_next   = hiu_reg;
        for (int i = 0; i < NS; i++) begin
            fm_next[i] = fm_reg[i];
        end
        ht_we    = 1'b0;
        ht_waddr = h_idx;
        ht_went  = '0;
        sv_we    = 1'b0;
        sv_waddr = {h_idx, idx_reg};
        sv_wdata = fm_reg[idx_reg];

        unique case (state_reg)
            emm_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = emm_pkg::S_EXEC;
                end
            end

            emm_pkg::S_EXEC: begin
                res_next   = '0;
                ent_next   = ht_rent;
                idx_next   = '0;
                state_next = emm_pkg::S_DONE;
                if (!act_reg) begin
                    // Byte access through the frame map
                    if (!off_reg[16] && fm_reg[off_slot].valid) begin
                        res_next.mapped         = 1'b1;
                        res_next.backing_handle = fm_reg[off_slot].handle;
                        res_next.backing_page   = fm_reg[off_slot].page;
                        res_next.backing_offset = off_reg[emm_pkg::PAGE_OFF_W-1:0];
                    end
                end else begin
                    unique case (fn_reg)
                        emm_pkg::FN_STATUS: begin
                        end
                        emm_pkg::FN_FRAME_SEG: begin
                            res_next.result_bx = seg_reg;
                        end
                        emm_pkg::FN_PAGE_COUNTS: begin
                            res_next.result_bx = (tot > piu_reg) ? 16'(tot - piu_reg) : '0;
                            res_next.result_dx = 16'(tot);
                        end
                        emm_pkg::FN_ALLOCATE: begin
                            if (pc_reg == '0) begin
                                res_next.status = emm_pkg::ST_ZERO_COUNT;
                            end else if (pc_reg > 16'(tot)) begin
                                res_next.status = emm_pkg::ST_OVER_TOTAL;
                            end else if (alloc_sum > 17'(tot)) begin
                                res_next.status = emm_pkg::ST_OVER_FREE;
                            end else begin
                                scan_next  = HW'(1);
                                state_next = emm_pkg::S_ASCAN;
                            end
                        end
                        emm_pkg::FN_MAP: begin
                            if (slot_reg >= 8'(NS)) begin
                                res_next.status = emm_pkg::ST_BAD_FRAME;
                            end else if (!hok) begin
                                res_next.status = emm_pkg::ST_BAD_HANDLE;
                            end else if (pc_reg == emm_pkg::UNMAP_PAGE) begin
                                fm_next[slot_reg[SW-1:0]] = '0;
                            end else if (pc_reg >= 16'(ht_rent.pages)) begin
                                res_next.status = emm_pkg::ST_PAGE_RANGE;
                            end else begin
                                fm_next[slot_reg[SW-1:0]].valid  = 1'b1;
                                fm_next[slot_reg[SW-1:0]].handle =
                                    h_reg[emm_pkg::HANDLE_FIELD_W-1:0];
                                fm_next[slot_reg[SW-1:0]].page   =
                                    pc_reg[emm_pkg::PAGE_FIELD_W-1:0];
                            end
                        end
                        emm_pkg::FN_DEALLOCATE: begin
                            if (!hok) begin
                                res_next.status = emm_pkg::ST_BAD_HANDLE;
                            end else if (ht_rent.saved) begin
                                res_next.status = emm_pkg::ST_MAP_SAVED;
                            end else begin
                                for (int i = 0; i < NS; i++) begin
                                    if (fm_reg[i].valid && fm_reg[i].handle ==
                                        h_reg[emm_pkg::HANDLE_FIELD_W-1:0]) begin
                                        fm_next[i] = '0;
                                    end
                                end
                                // Reserved handle 0 leaves the used-page count alone
                                if (h_reg != '0) begin
                                    piu_next = (piu_reg > ht_rent.pages)
                                             ? piu_reg - ht_rent.pages : '0;
                                end
                                if (hiu_reg != '0) begin
                                    hiu_next = hiu_reg - 1'b1;
                                end
                                ht_we   = 1'b1;
                                ht_went = '0;
                            end
                        end
                        emm_pkg::FN_VERSION: begin
                            res_next.result_al = emm_pkg::VERSION_BYTE;
                        end
                        emm_pkg::FN_SAVE_MAP: begin
                            if (!hok) begin
                                res_next.status = emm_pkg::ST_BAD_HANDLE;
                            end else if (ht_rent.saved) begin
                                res_next.status = emm_pkg::ST_ALREADY_SAVED;
                            end else begin
                                state_next = emm_pkg::S_SAVE;
                            end
                        end
                        emm_pkg::FN_RESTORE_MAP: begin
                            if (!hok) begin
                                res_next.status = emm_pkg::ST_BAD_HANDLE;
                            end else if (!ht_rent.saved) begin
                                res_next.status = emm_pkg::ST_NONE_SAVED;
                            end else begin
                                state_next = emm_pkg::S_RRD;
                            end
                        end
                        emm_pkg::FN_HANDLE_CNT: begin
                            res_next.result_bx = 16'(hiu_reg);
                        end
                        emm_pkg::FN_HANDLE_PGS: begin
                            if (!hok) begin
                                res_next.status = emm_pkg::ST_BAD_HANDLE;
                            end else begin
                                res_next.result_bx = 16'(ht_rent.pages);
                            end
                        end
                        default: begin
                            res_next.status = emm_pkg::ST_UNKNOWN_FN;
                        end
                    endcase
                end
            end

            // Allocate: one handle read, then its check
            emm_pkg::S_ASCAN: begin
                state_next = emm_pkg::S_ACHK;
            end

            emm_pkg::S_ACHK: begin
                if (!ht_rent.in_use) begin
                    ht_we          = 1'b1;
                    ht_waddr       = scan_reg;
                    ht_went.in_use = 1'b1;
                    ht_went.saved  = 1'b0;
                    ht_went.pages  = pc_reg[emm_pkg::COUNT_W-1:0];
                    piu_next       = piu_reg + pc_reg[emm_pkg::COUNT_W-1:0];
                    hiu_next       = hiu_reg + 1'b1;
                    res_next.result_dx = 16'(scan_reg);
                    state_next     = emm_pkg::S_DONE;
                end else if (32'(scan_reg) + 2 < emm_pkg::NUM_HANDLES) begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = emm_pkg::S_ASCAN;
                end else begin
                    res_next.status = emm_pkg::ST_NO_HANDLE;
                    state_next      = emm_pkg::S_DONE;
                end
            end

            // Save: copy one slot per cycle, marking the handle with the last slot
            emm_pkg::S_SAVE: begin
                sv_we    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SW'(NS - 1)) begin
                    ht_we         = 1'b1;
                    ht_went       = ent_reg;
                    ht_went.saved = 1'b1;
                    state_next    = emm_pkg::S_DONE;
                end
            end

            // Restore: read saved slot, read its handle, then check and load
            emm_pkg::S_RRD: begin
                state_next = emm_pkg::S_RHRD;
            end

            emm_pkg::S_RHRD: begin
                sv_next    = sv_rslot;
                state_next = emm_pkg::S_RCHK;
            end

            emm_pkg::S_RCHK: begin
                fm_next[idx_reg] = restore_ok ? sv_reg : '0;
                idx_next         = idx_reg + 1'b1;
                if (idx_reg == SW'(NS - 1)) begin
                    ht_we         = 1'b1;
                    ht_went       = ent_reg;
                    ht_went.saved = 1'b0;
                    state_next    = emm_pkg::S_DONE;
                end else begin
                    state_next = emm_pkg::S_RRD;
                end
            end

            emm_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = emm_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = emm_pkg::S_IDLE;
            end
        endcase
    end

    // Request capture and working payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_tuser;
            fn_reg   <= s_req.function_code;
            slot_reg <= s_req.frame_slot;
            pc_reg   <= s_req.page_or_count;
            h_reg    <= s_req.handle_number;
            off_reg  <= s_req.window_offset;
        end
        ent_reg  <= ent_next;
        idx_reg  <= idx_next;
        scan_reg <= scan_next;
        sv_reg   <= sv_next;
        res_reg  <= res_next;
    end

    // Frame map, counters and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                fm_reg[i] <= '0;
            end
            piu_reg   <= '0;
            hiu_reg   <= emm_pkg::HCOUNT_W'(1);
            seg_reg   <= emm_pkg::FRAME_SEG_RST;
            total_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                fm_reg[i] <= fm_next[i];
            end
            piu_reg <= piu_next;
            hiu_reg <= hiu_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    emm_pkg::REG_FRAME_SEGMENT: seg_reg   <= cfg_wdata;
                    emm_pkg::REG_TOTAL_PAGES:   total_reg <= cfg_wdata[emm_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == emm_pkg::S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == emm_pkg::S_DONE && (!m_tvalid_reg || m_tready)) begin
            out_reg <= res_reg;
        end
    end

    // Checks
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == emm_pkg::S_EXEC)
        else $error("accepted request did not enter execute");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == emm_pkg::S_DONE && m_tvalid_reg && !m_tready
        |=> state_reg == emm_pkg::S_DONE)
        else $error("result left while output register was blocked");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == emm_pkg::S_ASCAN
        |-> scan_reg != '0 && scan_reg != HW'(emm_pkg::NUM_HANDLES - 1))
        else $error("allocation scan outside handles 1 to top-1");

    a_pages_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        piu_reg <= emm_pkg::COUNT_W'(emm_pkg::MAX_PAGES)
        && hiu_reg <= emm_pkg::HCOUNT_W'(emm_pkg::NUM_HANDLES))
        else $error("page or handle count out of range");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the expanded memory page mapper top level.
`timescale 1ns / 1ps

module tb_top;

    // Function codes outside the implemented set
    localparam logic [7:0] FN_IO_PORTS       = 8'h49;
    localparam logic [7:0] FN_ALL_HANDLE_PGS = 8'h4D;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic [emm_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [emm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic                          cfg_addr = 1'b0;
    logic [15:0]                   cfg_wdata = '0;

    expanded_memory_page_mapper_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Idle and stall levels, percent
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int errors = 0;
    int quiet_cycles = 0;

    // Mirror of the mapper state
    logic [15:0]        seg_m;
    logic [11:0]        total_m;
    bit                 used_m  [emm_pkg::NUM_HANDLES];
    logic [11:0]        pages_m [emm_pkg::NUM_HANDLES];
    bit                 saved_m [emm_pkg::NUM_HANDLES];
    emm_pkg::slot_map_t snap_m  [emm_pkg::NUM_HANDLES][emm_pkg::NUM_FRAME_SLOTS];
    emm_pkg::slot_map_t frame_m [emm_pkg::NUM_FRAME_SLOTS];
    logic [11:0]        pages_used_m;
    logic [8:0]         handles_used_m;

    emm_pkg::res_t expected_results[$];

    function automatic void mirror_reset();
        seg_m = emm_pkg::FRAME_SEG_RST;
        total_m = '0;
        for (int i = 0; i < emm_pkg::NUM_HANDLES; i++) begin
            used_m[i] = 0;
            pages_m[i] = '0;
            saved_m[i] = 0;
        end
        for (int i = 0; i < emm_pkg::NUM_FRAME_SLOTS; i++) frame_m[i] = '0;
        used_m[0] = 1;
        pages_m[0] = emm_pkg::HANDLE0_PAGES;
        pages_used_m = '0;
        handles_used_m = 9'd1;
    endfunction

    // Compute the answer of one request and update the mirror
    function automatic emm_pkg::res_t predict_answer(bit act, emm_pkg::req_t r);
        emm_pkg::res_t o;
        int tot, pc, h, s, sh, off;
        bit hok;
        o = '0;
        pc = int'(r.page_or_count);
        h = int'(r.handle_number);
        off = int'(r.window_offset);
        hok = (h < emm_pkg::NUM_HANDLES) && used_m[h < emm_pkg::NUM_HANDLES ? h : 0];
        tot = (int'(total_m) > emm_pkg::MAX_PAGES) ? emm_pkg::MAX_PAGES : int'(total_m);
        if (!act) begin
            if (off <= 'hFFFF) begin
                s = (off / emm_pkg::PAGE_BYTES) % emm_pkg::NUM_FRAME_SLOTS;
                if (frame_m[s].valid) begin
                    o.mapped = 1'b1;
                    o.backing_handle = frame_m[s].handle;
                    o.backing_page = frame_m[s].page;
                    o.backing_offset = 14'(off % emm_pkg::PAGE_BYTES);
                end
            end
            return o;
        end
        case (r.function_code)
            emm_pkg::FN_STATUS: ;
            emm_pkg::FN_FRAME_SEG: o.result_bx = seg_m;
            emm_pkg::FN_PAGE_COUNTS: begin
                o.result_bx = (tot > int'(pages_used_m)) ? 16'(tot - int'(pages_used_m)) : '0;
                o.result_dx = 16'(tot);
            end
            emm_pkg::FN_ALLOCATE: begin
                if (pc == 0) o.status = emm_pkg::ST_ZERO_COUNT;
                else if (pc > tot) o.status = emm_pkg::ST_OVER_TOTAL;
                else if (int'(pages_used_m) + pc > tot) o.status = emm_pkg::ST_OVER_FREE;
                else begin
                    o.status = emm_pkg::ST_NO_HANDLE;
                    for (int i = 1; i + 1 < emm_pkg::NUM_HANDLES; i++) begin
                        if (!used_m[i]) begin
                            used_m[i] = 1;
                            pages_m[i] = 12'(pc);
                            saved_m[i] = 0;
                            pages_used_m = 12'(int'(pages_used_m) + pc);
                            handles_used_m++;
                            o.result_dx = 16'(i);
                            o.status = emm_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            emm_pkg::FN_MAP: begin
                if (int'(r.frame_slot) >= emm_pkg::NUM_FRAME_SLOTS)
                    o.status = emm_pkg::ST_BAD_FRAME;
                else if (!hok) o.status = emm_pkg::ST_BAD_HANDLE;
                else if (r.page_or_count == emm_pkg::UNMAP_PAGE)
                    frame_m[r.frame_slot[emm_pkg::SLOT_W-1:0]] = '0;
                else if (pc >= int'(pages_m[h])) o.status = emm_pkg::ST_PAGE_RANGE;
                else frame_m[r.frame_slot[emm_pkg::SLOT_W-1:0]] = '{1'b1, h[7:0], pc[10:0]};
            end
            emm_pkg::FN_DEALLOCATE: begin
                if (!hok) o.status = emm_pkg::ST_BAD_HANDLE;
                else if (saved_m[h]) o.status = emm_pkg::ST_MAP_SAVED;
                else begin
                    for (int i = 0; i < emm_pkg::NUM_FRAME_SLOTS; i++)
                        if (frame_m[i].valid && frame_m[i].handle == h[7:0]) frame_m[i] = '0;
                    if (h != 0)
                        pages_used_m = (pages_used_m > pages_m[h]) ?
                                       pages_used_m - pages_m[h] : '0;
                    used_m[h] = 0;
                    pages_m[h] = '0;
                    if (handles_used_m > 0) handles_used_m--;
                end
            end
            emm_pkg::FN_VERSION: o.result_al = emm_pkg::VERSION_BYTE;
            emm_pkg::FN_SAVE_MAP: begin
                if (!hok) o.status = emm_pkg::ST_BAD_HANDLE;
                else if (saved_m[h]) o.status = emm_pkg::ST_ALREADY_SAVED;
                else begin
                    for (int i = 0; i < emm_pkg::NUM_FRAME_SLOTS; i++)
                        snap_m[h][i] = frame_m[i];
                    saved_m[h] = 1;
                end
            end
            emm_pkg::FN_RESTORE_MAP: begin
                if (!hok) o.status = emm_pkg::ST_BAD_HANDLE;
                else if (!saved_m[h]) o.status = emm_pkg::ST_NONE_SAVED;
                else begin
                    for (int i = 0; i < emm_pkg::NUM_FRAME_SLOTS; i++) begin
                        sh = int'(snap_m[h][i].handle);
                        if (snap_m[h][i].valid && used_m[sh] &&
                            snap_m[h][i].page < pages_m[sh])
                            frame_m[i] = snap_m[h][i];
                        else frame_m[i] = '0;
                    end
                    saved_m[h] = 0;
                end
            end
            emm_pkg::FN_HANDLE_CNT: o.result_bx = 16'(handles_used_m);
            emm_pkg::FN_HANDLE_PGS: begin
                if (!hok) o.status = emm_pkg::ST_BAD_HANDLE;
                else o.result_bx = 16'(pages_m[h]);
            end
            default: o.status = emm_pkg::ST_UNKNOWN_FN;
        endcase
        return o;
    endfunction

    // Send one request; expectation is queued at acceptance
    task automatic send_request(bit act, emm_pkg::req_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        r.pad = '0;
        s_tdata <= r;
        s_tuser <= act;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_answer(act, r));
        @(negedge aclk);
    endtask

    task automatic call_fn(logic [7:0] fn, int slot, int pc, int h);
        emm_pkg::req_t r;
        r = '0;
        r.function_code = fn;
        r.frame_slot = 8'(slot);
        r.page_or_count = 16'(pc);
        r.handle_number = 16'(h);
        r.window_offset = 17'($urandom);
        send_request(1'b1, r);
    endtask

    task automatic access_byte(int off);
        emm_pkg::req_t r;
        r = '0;
        r.function_code = 8'($urandom);
        r.frame_slot = 8'($urandom);
        r.page_or_count = 16'($urandom);
        r.handle_number = 16'($urandom);
        r.window_offset = 17'(off);
        send_request(1'b0, r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == emm_pkg::REG_FRAME_SEGMENT) seg_m = val;
        else total_m = val[11:0];
    endtask

    // Receiver ready, with random stalls and a long hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        emm_pkg::res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status || got.result_bx != want.result_bx ||
                    got.result_dx != want.result_dx || got.result_al != want.result_al ||
                    got.mapped != want.mapped || got.backing_handle != want.backing_handle ||
                    got.backing_page != want.backing_page ||
                    got.backing_offset != want.backing_offset) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(emm_pkg::REG_TOTAL_PAGES, 16'd40);
        call_fn(emm_pkg::FN_STATUS, 0, 0, 0);
        call_fn(emm_pkg::FN_FRAME_SEG, 0, 0, 0);
        call_fn(emm_pkg::FN_VERSION, 0, 0, 0);
        call_fn(emm_pkg::FN_PAGE_COUNTS, 0, 0, 0);
        call_fn(emm_pkg::FN_ALLOCATE, 0, 0, 0);
        call_fn(emm_pkg::FN_ALLOCATE, 0, 41, 0);
        call_fn(emm_pkg::FN_ALLOCATE, 0, 30, 0);
        call_fn(emm_pkg::FN_ALLOCATE, 0, 20, 0);
        call_fn(emm_pkg::FN_MAP, 4, 0, 1);
        call_fn(emm_pkg::FN_MAP, 0, 0, 300);
        call_fn(emm_pkg::FN_MAP, 0, 30, 1);
        call_fn(emm_pkg::FN_MAP, 0, 29, 1);
        call_fn(emm_pkg::FN_MAP, 3, 3, 0);
        access_byte(0);
        access_byte('h0FFFF);
        access_byte('h10000);
        call_fn(emm_pkg::FN_SAVE_MAP, 0, 0, 1);
        call_fn(emm_pkg::FN_SAVE_MAP, 0, 0, 1);
        call_fn(emm_pkg::FN_DEALLOCATE, 0, 0, 1);
        call_fn(emm_pkg::FN_DEALLOCATE, 0, 0, 0);
        call_fn(emm_pkg::FN_RESTORE_MAP, 0, 0, 1);
        call_fn(emm_pkg::FN_RESTORE_MAP, 0, 0, 1);
        call_fn(FN_IO_PORTS, 0, 0, 0);
        call_fn(FN_ALL_HANDLE_PGS, 0, 0, 0);
        call_fn(emm_pkg::FN_HANDLE_CNT, 0, 0, 0);
        call_fn(emm_pkg::FN_HANDLE_PGS, 0, 0, 65535);
    endtask

    // Mostly well-formed calls on handles 0 to 7, with byte accesses between them
    task automatic random_item();
        int k, h, fn;
        int codes[11] = '{emm_pkg::FN_STATUS, emm_pkg::FN_FRAME_SEG, emm_pkg::FN_PAGE_COUNTS,
                          emm_pkg::FN_ALLOCATE, emm_pkg::FN_MAP, emm_pkg::FN_DEALLOCATE,
                          emm_pkg::FN_VERSION, emm_pkg::FN_SAVE_MAP,
                          emm_pkg::FN_RESTORE_MAP, emm_pkg::FN_HANDLE_CNT,
                          emm_pkg::FN_HANDLE_PGS};
        k = $urandom_range(99);
        h = $urandom_range(7);
        if (k < 45) access_byte($urandom_range(99) < 5 ? $urandom_range(17'h1FFFF, 17'h10000)
                                                      : $urandom_range(16'hFFFF));
        else if (k < 60) call_fn(emm_pkg::FN_MAP,
                                 $urandom_range(99) < 90 ? $urandom_range(3) : $urandom,
                                 $urandom_range(99) < 10 ? 16'hFFFF : $urandom_range(20), h);
        else if (k < 70) call_fn(emm_pkg::FN_ALLOCATE, 0, $urandom_range(99) < 5 ? $urandom
                                                          : $urandom_range(12), 0);
        else if (k < 94) begin
            fn = codes[$urandom_range(10)];
            call_fn(fn[7:0], $urandom, $urandom, $urandom_range(99) < 8 ? $urandom : h);
        end else call_fn(8'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_phase(int sidle, int rstall, int n);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        repeat (n) random_item();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        hold_off = 300;
        repeat (20) random_item();
        wait_drained();
    endtask

    initial begin
        mirror_reset();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        write_reg(emm_pkg::REG_FRAME_SEGMENT, 16'hFFFF);
        write_reg(emm_pkg::REG_TOTAL_PAGES, 16'd200);
        test_random_phase(0, 0, 300);
        write_reg(emm_pkg::REG_FRAME_SEGMENT, 16'h0000);
        write_reg(emm_pkg::REG_TOTAL_PAGES, 16'hFFF);
        test_random_phase(73, 0, 300);
        test_backpressure();
        write_reg(emm_pkg::REG_TOTAL_PAGES, 16'd0);
        test_random_phase(0, 73, 150);
        write_reg(emm_pkg::REG_TOTAL_PAGES, 16'd2048);
        write_reg(emm_pkg::REG_FRAME_SEGMENT, 16'($urandom));
        test_random_phase(0, 73, 150);
        test_random_phase(29, 29, 300);
        wait_drained();
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
